FILE: sv/heat_diffusion_grid_steady_cache_top_macros.svh
// Assertion macros for the heat diffusion grid block
`ifndef HEAT_DIFFUSION_GRID_STEADY_CACHE_TOP_MACROS_SVH
`define HEAT_DIFFUSION_GRID_STEADY_CACHE_TOP_MACROS_SVH
// implication checked every clock outside reset
`define HDG_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication checked outside reset
`define HDG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

FILE: sv/hdg_pkg.sv
`timescale 1ns / 1ps
package hdg_pkg;
  localparam int MaxWidth  = 64;
  localparam int MaxHeight = 64;
  localparam logic [1:0] ModeCached   = 2'd0;
  localparam logic [1:0] ModeChecking = 2'd1;
  localparam logic [1:0] ModeForced   = 2'd2;
  localparam logic [2:0] FuncRead  = 3'd0;
  localparam logic [2:0] FuncWrite = 3'd1;
  localparam logic [2:0] FuncTick  = 3'd2;
  localparam logic [2:0] FuncForce = 3'd3;
  localparam logic [2:0] FuncInit  = 3'd4;
  localparam logic [2:0] CfgFactor  = 3'd0;
  localparam logic [2:0] CfgEpsilon = 3'd1;
  localparam logic [2:0] CfgAmbient = 3'd2;
  localparam logic [2:0] CfgWidth   = 3'd3;
  localparam logic [2:0] CfgHeight  = 3'd4;
  localparam logic [16:0] CountMax  = 17'd131071;

  typedef struct packed {
    logic [2:0]         func;
    logic [5:0]         cell_x;
    logic [5:0]         cell_y;
    logic signed [31:0] heat_value;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] read_heat;
    logic [1:0]         mode;
    logic [31:0]        max_gradient;
    logic               steady_reached;
  } rsp_t;

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    if (v > 36'sd2147483647) return 32'sh7fffffff;
    if (v < -36'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic [31:0] abs_diff(input logic signed [31:0] a,
                                           input logic signed [31:0] b);
    logic signed [32:0] d;
    d = 33'(a) - 33'(b);
    if (d < 0) d = -d;
    return d[31:0];
  endfunction
endpackage

FILE: sv/hdg_ram.sv
`timescale 1ns / 1ps
module hdg_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

FILE: sv/heat_diffusion_grid_steady_cache_top.sv
`timescale 1ns / 1ps
// A tick in updating mode sweeps the grid through the single heat memory read port,
// reading five cells per interior cell and two per last-row or last-column cell.
// One transaction in flight: no new command is taken until the result; the result
// strobe is one cycle, the receiver cannot stall. Reset sets mode to checking and
// clears buffer select, countdown and gradient; the heat memory holds no reset and
// reads undefined until initialized or written.
module heat_diffusion_grid_steady_cache_top #(
  parameter int MaxWidth  = hdg_pkg::MaxWidth,
  parameter int MaxHeight = hdg_pkg::MaxHeight
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  hdg_pkg::cmd_t cmd_i,
  output logic          done_o,
  output hdg_pkg::rsp_t rsp_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [2:0]    cfg_index_i,
  input  logic [31:0]   cfg_data_i
);
  localparam int XW = $clog2(MaxWidth);
  localparam int YW = $clog2(MaxHeight);
  localparam int AW = 1 + XW + YW;
  localparam int Plane = MaxWidth * MaxHeight;

  typedef enum logic [8:0] {
    StIdle  = 9'b000000001,
    StWrRd  = 9'b000000010,
    StWr    = 9'b000000100,
    StInit  = 9'b000001000,
    StTkRd  = 9'b000010000,
    StTkCal = 9'b000100000,
    StTkWr  = 9'b001000000,
    StOutRd = 9'b010000000,
    StOut   = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  // configuration registers, written only between transactions
  logic [16:0] factor_q;
  logic [30:0] eps_q;
  logic signed [31:0] amb_q;
  logic [6:0] gw_q, gh_q;
  assign cfg_ready_o = !busy;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      factor_q <= '0; eps_q <= 31'd6554; amb_q <= '0; gw_q <= 7'd64; gh_q <= 7'd64;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        hdg_pkg::CfgFactor:  factor_q <= cfg_data_i[16:0];
        hdg_pkg::CfgEpsilon: eps_q <= cfg_data_i[30:0];
        hdg_pkg::CfgAmbient: amb_q <= cfg_data_i;
        hdg_pkg::CfgWidth:   gw_q <= cfg_data_i[6:0];
        hdg_pkg::CfgHeight:  gh_q <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // effective grid size, 9 bits holds up to 511
  logic [8:0] w_eff, h_eff;
  always_comb begin
    w_eff = (gw_q < 7'd3) ? 9'd3 : 9'(gw_q);
    if (w_eff > 9'(MaxWidth)) w_eff = 9'(MaxWidth);
    h_eff = (gh_q < 7'd3) ? 9'd3 : 9'(gh_q);
    if (h_eff > 9'(MaxHeight)) h_eff = 9'(MaxHeight);
  end

  // control state
  hdg_pkg::cmd_t cmd_q;
  logic        act_q;
  logic [1:0]  mode_q;
  logic [16:0] cnt_q;
  logic [31:0] mg_q, mgrun_q;
  logic        steady_q;
  logic [8:0]  x_q, y_q;
  logic        b_q;
  logic [2:0]  k_q;
  logic signed [31:0] nb_q [5];
  logic [16:0] fsat;
  assign fsat = (factor_q > 17'd65536) ? 17'd65536 : factor_q;

  // memory
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   wdata, rdata;
  hdg_ram #(.Width(32), .Depth(2 * Plane)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  function automatic logic [AW-1:0] addr(input logic b, input logic [8:0] x,
                                          input logic [8:0] y);
    return {b, y[YW-1:0], x[XW-1:0]};
  endfunction

  logic [XW-1:0] cx;
  logic [YW-1:0] cy;
  assign cx = XW'(cmd_q.cell_x);
  assign cy = YW'(cmd_q.cell_y);

  // tick read offsets: center, up, left, down, right
  logic [8:0] rx, ry;
  always_comb begin
    rx = x_q; ry = y_q;
    case (k_q)
      3'd1: ry = y_q - 9'd1;
      3'd2: rx = x_q - 9'd1;
      3'd3: ry = y_q + 9'd1;
      3'd4: rx = x_q + 9'd1;
      default: ;
    endcase
  end

  // position classes in the sweep: x,y over 1..w-1 / 1..h-1
  logic interior, lastrow, lastcol;
  assign interior = (x_q < w_eff - 9'd1) && (y_q < h_eff - 9'd1);
  assign lastrow  = (y_q == h_eff - 9'd1) && (x_q < w_eff - 9'd1);
  assign lastcol  = (x_q == w_eff - 9'd1) && (y_q < h_eff - 9'd1);
  logic [2:0] nreads;
  assign nreads = interior ? 3'd5 : 3'd2;

  // stencil arithmetic: product register and combinational terms
  logic signed [35:0] lap;
  logic signed [31:0] lap_s;
  logic signed [49:0] prod_q;
  logic signed [33:0] delta;
  logic [31:0] dmax;
  always_comb begin
    lap = 36'(nb_q[1]) + 36'(nb_q[2]) + 36'(nb_q[3]) + 36'(nb_q[4]) - (36'(nb_q[0]) <<< 2);
    lap_s = hdg_pkg::sat32(lap);
    delta = 34'((prod_q + 50'sd32768) >>> 16);
    dmax = hdg_pkg::abs_diff(nb_q[0], nb_q[1]);
    if (interior && hdg_pkg::abs_diff(nb_q[0], nb_q[2]) > dmax)
      dmax = hdg_pkg::abs_diff(nb_q[0], nb_q[2]);
  end

  // 2000 * 256 + 1 fits in 20 bits
  logic [19:0] cnt_load;
  assign cnt_load = 20'(2000 * ((w_eff > h_eff) ? w_eff : h_eff) + 1);

  // memory port control
  always_comb begin
    we = 1'b0; waddr = addr(act_q, 9'(cx), 9'(cy)); wdata = cmd_q.heat_value;
    raddr = addr(act_q, 9'(cx), 9'(cy));
    case (state_q)
      StWr: we = 1'b1;
      StInit: begin
        we = 1'b1; waddr = addr(b_q, x_q, y_q); wdata = amb_q;
      end
      StTkRd: begin
        raddr = addr(act_q, rx, ry);
        if (!interior && k_q == 3'd1) raddr = lastrow ? addr(act_q, x_q, y_q - 9'd1)
                                                      : addr(act_q, x_q - 9'd1, y_q);
      end
      StTkWr: begin
        we = interior; waddr = addr(!act_q, x_q, y_q);
        wdata = hdg_pkg::sat32(36'(nb_q[0]) + 36'(delta));
      end
      default: ;
    endcase
  end

  logic rd_pend_q;
  logic [2:0] rk_q;
  logic sweep_end;
  // the sweep ends on the last cell of the last column
  assign sweep_end = (x_q == w_eff - 9'd1) && (y_q == h_eff - 9'd2);

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: if (start) begin
        case (cmd_i.func)
          hdg_pkg::FuncWrite: state_d = StWrRd;
          hdg_pkg::FuncInit:  state_d = StInit;
          hdg_pkg::FuncTick:
            state_d = (mode_q == hdg_pkg::ModeCached) ? StOutRd : StTkRd;
          default: state_d = StOutRd;
        endcase
      end
      StWrRd:  if (rd_pend_q) state_d = StWr;
      StWr:    state_d = StOutRd;
      StInit:
        if (b_q && x_q == w_eff - 9'd1 && y_q == h_eff - 9'd1) state_d = StOutRd;
      StTkRd:  if (rd_pend_q && rk_q == nreads - 3'd1) state_d = StTkCal;
      StTkCal: state_d = StTkWr;
      StTkWr:  state_d = sweep_end ? StOutRd : StTkRd;
      StOutRd: if (rd_pend_q) state_d = StOut;
      StOut:   state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  assign busy = (state_q != StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; act_q <= 1'b0; mode_q <= hdg_pkg::ModeChecking;
      cnt_q <= '0; mg_q <= '0; steady_q <= 1'b0; rd_pend_q <= 1'b0;
      k_q <= '0; rk_q <= '0; x_q <= '0; y_q <= '0; b_q <= 1'b0; mgrun_q <= '0;
    end else begin
      state_q <= state_d;
      // read pending flag: toggles on single reads, follows the tick read count
      rd_pend_q <= (state_q inside {StWrRd, StOutRd}) ? !rd_pend_q
                                                      : (state_q == StTkRd && k_q < nreads);
      case (state_q)
        StIdle: if (start) begin
          steady_q <= 1'b0; b_q <= 1'b0; k_q <= '0; mgrun_q <= '0;
          x_q <= (cmd_i.func == hdg_pkg::FuncInit) ? 9'd0 : 9'd1;
          y_q <= (cmd_i.func == hdg_pkg::FuncInit) ? 9'd0 : 9'd1;
          if (cmd_i.func == hdg_pkg::FuncForce && mode_q == hdg_pkg::ModeCached) begin
            mode_q <= hdg_pkg::ModeForced;
            cnt_q <= (cnt_load > 20'(hdg_pkg::CountMax)) ? hdg_pkg::CountMax
                                                         : cnt_load[16:0];
          end
        end
        StWr: if (mode_q == hdg_pkg::ModeCached &&
                  hdg_pkg::abs_diff(cmd_q.heat_value, rdata) > 32'(eps_q))
          mode_q <= hdg_pkg::ModeChecking;
        StInit: begin
          if (y_q == h_eff - 9'd1) begin
            y_q <= '0;
            if (x_q == w_eff - 9'd1) begin x_q <= '0; b_q <= 1'b1; end
            else x_q <= x_q + 9'd1;
          end else y_q <= y_q + 9'd1;
        end
        StTkRd: begin
          if (k_q < nreads) k_q <= k_q + 3'd1;
          rk_q <= k_q;
          if (rd_pend_q) nb_q[rk_q] <= rdata;
        end
        StTkCal: begin
          prod_q <= 50'(lap_s) * $signed({1'b0, fsat});
          if (dmax > mgrun_q) mgrun_q <= dmax;
        end
        StTkWr: begin
          k_q <= '0;
          if (y_q == h_eff - 9'd1 || (x_q == w_eff - 9'd1)) begin
            if (x_q == w_eff - 9'd1) y_q <= y_q + 9'd1;
            else if (x_q == w_eff - 9'd2) begin x_q <= w_eff - 9'd1; y_q <= 9'd1; end
            else x_q <= x_q + 9'd1;
          end else if (y_q == h_eff - 9'd2) begin
            if (x_q == w_eff - 9'd2) begin x_q <= 9'd1; y_q <= h_eff - 9'd1; end
            else begin x_q <= x_q + 9'd1; y_q <= 9'd1; end
          end else y_q <= y_q + 9'd1;
          if (sweep_end) begin
            act_q <= !act_q; mg_q <= mgrun_q;
            if (mode_q == hdg_pkg::ModeChecking) begin
              if (mgrun_q < 32'(eps_q)) begin
                mode_q <= hdg_pkg::ModeCached; steady_q <= 1'b1;
              end
            end else begin
              if (cnt_q <= 17'd1) begin
                cnt_q <= '0; mode_q <= hdg_pkg::ModeChecking;
              end else cnt_q <= cnt_q - 17'd1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) cmd_q <= cmd_i;
  end

  // result
  assign done_o = (state_q == StOut);
  always_comb begin
    rsp_o.read_heat = rdata;
    rsp_o.mode = mode_q;
    rsp_o.max_gradient = mg_q;
    rsp_o.steady_reached = steady_q;
  end

`include "heat_diffusion_grid_steady_cache_top_macros.svh"
  `HDG_ASSERT_IMPL(a_done_busy, clk_i, rst_ni, done_o, busy, "result outside transaction")
  `HDG_ASSERT_NEXT(a_done_once, clk_i, rst_ni, done_o, !done_o, "double result strobe")
  `HDG_ASSERT_IMPL(a_steady_mode, clk_i, rst_ni, done_o && rsp_o.steady_reached,
                   rsp_o.mode == hdg_pkg::ModeCached, "steady without cached mode")
  `HDG_ASSERT_IMPL(a_mode_code, clk_i, rst_ni, 1'b1, mode_q != 2'd3, "bad mode")
endmodule

FILE: test/heat_diffusion_grid_steady_cache_top_test.sv
`timescale 1ns / 1ps
module heat_diffusion_grid_steady_cache_top_test;

  localparam int  Plane     = hdg_pkg::MaxWidth * hdg_pkg::MaxHeight;
  localparam int  StallMax  = 200000;
  localparam int  NumRandom = 115;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  hdg_pkg::cmd_t cmd_i = '0;
  logic done_o;
  hdg_pkg::rsp_t rsp_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [2:0] cfg_index_i = hdg_pkg::CfgFactor;
  logic [31:0] cfg_data_i = '0;

  heat_diffusion_grid_steady_cache_top u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .cmd_i      (cmd_i),
    .done_o     (done_o),
    .rsp_o      (rsp_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  // Shadow copy of the grid state and registers
  logic signed [31:0] grid_mem [0:2*Plane-1];
  logic        cur_buf;
  logic [1:0]  cur_mode;
  logic [16:0] steps_left;
  logic [31:0] peak_gradient;
  logic [16:0] factor_reg;
  logic [30:0] epsilon_reg;
  logic signed [31:0] ambient_reg;
  logic [6:0]  width_reg;
  logic [6:0]  height_reg;

  hdg_pkg::cmd_t pending_cmds[$];
  hdg_pkg::rsp_t expected_rsps[$];
  int   mismatches;
  int   stall_cycles;
  int   cmd_count;
  int   steady_count;
  int   forced_count;
  int   wait_cnt;
  bit   cmd_taken;

  function automatic int cell_index(logic b, int x, int y);
    return int'(b) * Plane + (y % hdg_pkg::MaxHeight) * hdg_pkg::MaxWidth
           + (x % hdg_pkg::MaxWidth);
  endfunction

  function automatic logic signed [31:0] clamp_heat(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic [31:0] heat_gap(logic signed [31:0] a, logic signed [31:0] b);
    longint d;
    d = longint'(a) - longint'(b);
    if (d < 0) d = -d;
    return d[31:0];
  endfunction

  function automatic int used_width();
    return (width_reg < 3) ? 3 : (width_reg > hdg_pkg::MaxWidth) ? hdg_pkg::MaxWidth
                                                                : int'(width_reg);
  endfunction

  function automatic int used_height();
    return (height_reg < 3) ? 3 : (height_reg > hdg_pkg::MaxHeight) ? hdg_pkg::MaxHeight
                                                                   : int'(height_reg);
  endfunction

  // One Jacobi sweep into the idle buffer; returns the largest neighbor gap
  function automatic logic [31:0] diffuse_step();
    int w, h;
    logic a, nb;
    longint f, lap, prod;
    logic signed [31:0] c, up, lf;
    logic [31:0] mg, d;
    w = used_width();
    h = used_height();
    a = cur_buf;
    nb = ~cur_buf;
    f = (factor_reg > 17'd65536) ? 65536 : longint'(factor_reg);
    mg = '0;
    for (int x = 1; x + 1 < w; x++) begin
      for (int y = 1; y + 1 < h; y++) begin
        c = grid_mem[cell_index(a, x, y)];
        up = grid_mem[cell_index(a, x, y - 1)];
        lf = grid_mem[cell_index(a, x - 1, y)];
        lap = longint'(grid_mem[cell_index(a, x, y + 1)]) + longint'(up)
            + longint'(grid_mem[cell_index(a, x + 1, y)]) + longint'(lf) - 4 * longint'(c);
        prod = longint'(clamp_heat(lap)) * f;
        grid_mem[cell_index(nb, x, y)] = clamp_heat(longint'(c) + ((prod + 32768) >>> 16));
        d = heat_gap(c, up);
        if (d > mg) mg = d;
        d = heat_gap(c, lf);
        if (d > mg) mg = d;
      end
    end
    for (int x = 1; x + 1 < w; x++) begin
      d = heat_gap(grid_mem[cell_index(a, x, h - 1)], grid_mem[cell_index(a, x, h - 2)]);
      if (d > mg) mg = d;
    end
    for (int y = 1; y + 1 < h; y++) begin
      d = heat_gap(grid_mem[cell_index(a, w - 1, y)], grid_mem[cell_index(a, w - 2, y)]);
      if (d > mg) mg = d;
    end
    cur_buf = nb;
    peak_gradient = mg;
    return mg;
  endfunction

  // Apply one command to the shadow state and queue the expected response
  function automatic void predict_response(hdg_pkg::cmd_t c);
    hdg_pkg::rsp_t r;
    int idx, n;
    logic steady;
    steady = 1'b0;
    case (c.func)
      hdg_pkg::FuncWrite: begin
        idx = cell_index(cur_buf, int'(c.cell_x), int'(c.cell_y));
        if (cur_mode == hdg_pkg::ModeCached &&
            heat_gap(c.heat_value, grid_mem[idx]) > {1'b0, epsilon_reg})
          cur_mode = hdg_pkg::ModeChecking;
        grid_mem[idx] = c.heat_value;
      end
      hdg_pkg::FuncTick: begin
        if (cur_mode == hdg_pkg::ModeChecking) begin
          if (diffuse_step() < {1'b0, epsilon_reg}) begin
            cur_mode = hdg_pkg::ModeCached;
            steady = 1'b1;
          end
        end else if (cur_mode == hdg_pkg::ModeForced) begin
          void'(diffuse_step());
          if (steps_left > 0) steps_left--;
          if (steps_left == 0) cur_mode = hdg_pkg::ModeChecking;
        end
      end
      hdg_pkg::FuncForce: begin
        if (cur_mode == hdg_pkg::ModeCached) begin
          n = 2000 * ((used_width() > used_height()) ? used_width() : used_height()) + 1;
          cur_mode = hdg_pkg::ModeForced;
          steps_left = (n > int'(hdg_pkg::CountMax)) ? hdg_pkg::CountMax : 17'(n);
        end
      end
      hdg_pkg::FuncInit: begin
        for (int b = 0; b < 2; b++)
          for (int x = 0; x < used_width(); x++)
            for (int y = 0; y < used_height(); y++)
              grid_mem[cell_index(b[0], x, y)] = ambient_reg;
      end
      default: ;
    endcase
    r.read_heat = grid_mem[cell_index(cur_buf, int'(c.cell_x), int'(c.cell_y))];
    r.mode = cur_mode;
    r.max_gradient = peak_gradient;
    r.steady_reached = steady;
    if (steady) steady_count++;
    if (cur_mode == hdg_pkg::ModeForced) forced_count++;
    expected_rsps.push_back(r);
  endfunction

  function automatic void report_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %s: expected %h, got %h at %0t", name, exp_v, act_v, $realtime);
    end
  endfunction

  // Command driver: inputs change on the falling edge
  always @(negedge clk_i) begin : drive_cmds
    logic nxt;
    nxt = start;
    if (rst_ni) begin
      if (cmd_taken) begin
        nxt = 1'b0;
        cmd_taken = 1'b0;
        wait_cnt = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 11);
      end
      if (!nxt && pending_cmds.size() > 0) begin
        if (wait_cnt == 0) begin
          nxt = 1'b1;
          cmd_i <= pending_cmds[0];
        end else begin
          wait_cnt--;
        end
      end
    end
    start <= nxt;
  end

  // Monitor: transaction accept, response check and watchdog on the rising edge
  always @(posedge clk_i) begin : watch_rsps
    hdg_pkg::rsp_t exp_r;
    logic moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (start && !busy && !cmd_taken) begin
        predict_response(pending_cmds.pop_front());
        cmd_taken = 1'b1;
        cmd_count++;
        moved = 1'b1;
      end
      if (cfg_valid_i && cfg_ready_o) moved = 1'b1;
      if (done_o) begin
        moved = 1'b1;
        if (expected_rsps.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("response with nothing expected at %0t", $realtime);
        end else begin
          exp_r = expected_rsps.pop_front();
          report_field("read_heat", exp_r.read_heat, rsp_o.read_heat);
          report_field("mode", 32'(exp_r.mode), 32'(rsp_o.mode));
          report_field("max_gradient", exp_r.max_gradient, rsp_o.max_gradient);
          report_field("steady_reached", 32'(exp_r.steady_reached), 32'(rsp_o.steady_reached));
        end
      end
    end
    stall_cycles = moved ? 0 : stall_cycles + 1;
    if (stall_cycles >= StallMax) begin
      $display("watchdog expired at %0t", $realtime);
      $display("** heat_diffusion_grid_steady_cache_top: FAILED **");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      hdg_pkg::CfgFactor:  factor_reg = data[16:0];
      hdg_pkg::CfgEpsilon: epsilon_reg = data[30:0];
      hdg_pkg::CfgAmbient: ambient_reg = data;
      hdg_pkg::CfgWidth:   width_reg = data[6:0];
      hdg_pkg::CfgHeight:  height_reg = data[6:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_regs(logic [31:0] f, logic [31:0] e, logic [31:0] a,
                          logic [31:0] w, logic [31:0] h);
    write_reg(hdg_pkg::CfgFactor, f);
    write_reg(hdg_pkg::CfgEpsilon, e);
    write_reg(hdg_pkg::CfgAmbient, a);
    write_reg(hdg_pkg::CfgWidth, w);
    write_reg(hdg_pkg::CfgHeight, h);
  endtask

  task automatic push_cmd(logic [2:0] f, int x, int y, logic [31:0] v);
    hdg_pkg::cmd_t c;
    c.func = f;
    c.cell_x = x[5:0];
    c.cell_y = y[5:0];
    c.heat_value = v;
    pending_cmds.push_back(c);
  endtask

  task automatic drain();
    while (pending_cmds.size() != 0 || expected_rsps.size() != 0) @(posedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  // Random command mix: mostly writes and ticks, plus reads, forced recomputes, initializes and unknown funcs
  task automatic push_random(int n);
    int sel;
    logic [31:0] v;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 99);
      v = ($urandom_range(0, 1) == 0) ? $urandom : ambient_reg + $urandom_range(0, 4000) - 2000;
      if (sel < 20)
        push_cmd(hdg_pkg::FuncRead, $urandom_range(0, 63), $urandom_range(0, 63), $urandom);
      else if (sel < 50)
        push_cmd(hdg_pkg::FuncWrite, $urandom_range(0, 63), $urandom_range(0, 63), v);
      else if (sel < 80)
        push_cmd(hdg_pkg::FuncTick, $urandom_range(0, 63), $urandom_range(0, 63), v);
      else if (sel < 90)
        push_cmd(hdg_pkg::FuncForce, $urandom_range(0, 63), $urandom_range(0, 63), v);
      else if (sel < 95)
        push_cmd(hdg_pkg::FuncInit, $urandom_range(0, 63), $urandom_range(0, 63), v);
      else push_cmd(3'($urandom_range(5, 7)), $urandom_range(0, 63), $urandom_range(0, 63), v);
    end
  endtask

  initial begin
    cur_buf = 1'b0;
    cur_mode = hdg_pkg::ModeChecking;
    steps_left = '0;
    peak_gradient = '0;
    factor_reg = '0;
    epsilon_reg = 31'd6554;
    ambient_reg = '0;
    width_reg = 7'd64;
    height_reg = 7'd64;
    mismatches = 0;
    stall_cycles = 0;
    cmd_count = 0;
    steady_count = 0;
    forced_count = 0;
    wait_cnt = 0;
    cmd_taken = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Full grid at reset settings: initialize first so every cell is defined
    push_cmd(hdg_pkg::FuncInit, 0, 0, 0);
    push_cmd(hdg_pkg::FuncRead, 0, 0, 0);
    push_cmd(hdg_pkg::FuncWrite, 63, 63, 32'h80000000);
    push_cmd(hdg_pkg::FuncWrite, 0, 0, 32'h7fffffff);
    push_cmd(hdg_pkg::FuncRead, 63, 63, 32'hffffffff);
    push_cmd(hdg_pkg::FuncTick, 63, 63, 0);
    push_cmd(hdg_pkg::FuncForce, 1, 1, 0);
    push_cmd(3'd5, 0, 0, 0);
    push_cmd(3'd7, 63, 63, 0);
    drain();

    // Smallest grid, extreme registers: saturation, then steady and forced modes
    set_regs(32'd65536, 32'h7fffffff, 32'h80000000, 3, 3);
    push_cmd(hdg_pkg::FuncInit, 1, 1, 0);
    push_cmd(hdg_pkg::FuncWrite, 1, 1, 32'h7fffffff);
    push_cmd(hdg_pkg::FuncWrite, 1, 0, 32'h7fffffff);
    push_cmd(hdg_pkg::FuncTick, 1, 1, 0);
    push_cmd(hdg_pkg::FuncInit, 0, 0, 0);
    push_cmd(hdg_pkg::FuncTick, 1, 1, 0);
    push_cmd(hdg_pkg::FuncWrite, 2, 2, 32'h80000010);
    push_cmd(hdg_pkg::FuncForce, 1, 1, 0);
    push_cmd(hdg_pkg::FuncTick, 1, 1, 0);
    push_cmd(hdg_pkg::FuncWrite, 1, 1, 32'h7fffffff);
    push_cmd(hdg_pkg::FuncTick, 1, 1, 0);
    push_cmd(hdg_pkg::FuncRead, 40, 50, 0);
    push_cmd(hdg_pkg::FuncTick, 1, 1, 0);
    push_cmd(hdg_pkg::FuncForce, 1, 1, 0);
    drain();

    // Out-of-range sizes clamp; oversized factor counts as one
    set_regs(32'h1ffff, 0, 32'h00010000, 0, 127);
    push_cmd(hdg_pkg::FuncInit, 2, 63, 0);
    push_cmd(hdg_pkg::FuncWrite, 1, 30, 32'h7fff0000);
    push_cmd(hdg_pkg::FuncTick, 1, 30, 0);
    push_cmd(hdg_pkg::FuncTick, 1, 31, 0);
    drain();

    // Random phases over small grids with varied factors and thresholds
    for (int p = 0; p < 5; p++) begin
      set_regs(($urandom_range(0, 2) == 0) ? 32'd0 : $urandom_range(8192, 65536),
               ($urandom_range(0, 1) == 0) ? 32'h7fffffff : $urandom_range(0, 32'h00100000),
               $urandom, $urandom_range(2, 8), $urandom_range(2, 8));
      push_cmd(hdg_pkg::FuncInit, 0, 0, 0);
      push_random(NumRandom / 5);
      drain();
    end
    repeat (20) @(posedge clk_i);

    $display("ran %0d commands: %0d steady transitions, %0d responses in forced mode",
             cmd_count, steady_count, forced_count);
    $display("sizes from clamped 3x3 up to 64x64, factor and threshold at both ends");
    if (mismatches == 0 && expected_rsps.size() == 0) begin
      $display("** heat_diffusion_grid_steady_cache_top: PASSED **");
    end else begin
      $display("%0d mismatches, %0d responses missing", mismatches, expected_rsps.size());
      $display("** heat_diffusion_grid_steady_cache_top: FAILED **");
    end
    $finish;
  end
endmodule
